// File: hdl/btsp_pkg.sv
// btsp_pkg: shared types and constants for the ber tlv stream parser
// word structs for the input and result channels, phase encoding, byte roles
// no dependencies
package btsp_pkg;

    // limits on multi-byte fields
    localparam int MAX_TAG_BYTES = 4;
    localparam int MAX_LEN_BYTES = 4;

    localparam int TAG_W       = 28;
    localparam int LEN_W       = 32;
    localparam int DEPTH_W     = 4;
    localparam int TAG_CNT_W   = $clog2(MAX_TAG_BYTES + 1);
    localparam int LEN_CNT_W   = $clog2(MAX_LEN_BYTES + 1);

    // identifier and length byte constants
    localparam logic [7:0] TAG_NUM_MASK  = 8'h1F;
    localparam logic [7:0] PRINT_LOW     = 8'h20;
    localparam logic [7:0] PRINT_HIGH    = 8'h7E;
    localparam logic [6:0] LEN_RESERVED  = 7'h7F;
    localparam logic [7:0] LEN_INDEF     = 8'h80;

    // byte role codes on the result word
    localparam logic [2:0] ROLE_TAG_FIRST = 3'd0;
    localparam logic [2:0] ROLE_TAG_CONT  = 3'd1;
    localparam logic [2:0] ROLE_LEN_FIRST = 3'd2;
    localparam logic [2:0] ROLE_LEN_CONT  = 3'd3;
    localparam logic [2:0] ROLE_CONTENT   = 3'd4;

    typedef enum logic [4:0] {
        PH_TAG_FIRST = 5'b00001,
        PH_TAG_CONT  = 5'b00010,
        PH_LEN_FIRST = 5'b00100,
        PH_LEN_CONT  = 5'b01000,
        PH_CONTENT   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         byte_role;
        logic [1:0]         tag_class;
        logic               constructed;
        logic [TAG_W-1:0]   tag_number;
        logic [LEN_W-1:0]   content_length;
        logic               indefinite;
        logic               header_done;
        logic               end_of_contents;
        logic [DEPTH_W-1:0] nest_depth;
        logic               content_last;
        logic               printable;
        logic               error;
    } out_item_t;

endpackage

// File: hdl/ber_tlv_stream_parser.sv
// ber_tlv_stream_parser: byte-serial asn.1 ber identifier/length decoder
// one result word per input word; depends on btsp_pkg
//
// a word goes from the input register through the decode into the result register
// throughput: one word per cycle while the receiver does not stall, limited by the
// combinational decode between the input register and the result register
// reset (rst_n low, async): parser expects a tag first byte at depth zero,
// both pipeline stages empty, depth_limit back to 15
module ber_tlv_stream_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  btsp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output btsp_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata
);
    import btsp_pkg::*;

    // input stage
    logic     s1_valid_reg;
    in_item_t s1_data_reg;

    // result stage
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    // parser state
    phase_t               phase_reg,       phase_next;
    logic [TAG_W-1:0]     tag_accum_reg,   tag_accum_next;
    logic [TAG_CNT_W-1:0] tag_cnt_reg,     tag_cnt_next;
    logic [1:0]           class_reg,       class_next;
    logic                 cons_reg,        cons_next;
    logic [LEN_W-1:0]     len_accum_reg,   len_accum_next;
    logic [LEN_CNT_W-1:0] len_left_reg,    len_left_next;
    logic [LEN_W-1:0]     content_left_reg, content_left_next;
    logic                 printable_reg,   printable_next;
    logic [DEPTH_W-1:0]   depth_reg,       depth_next;
    logic [DEPTH_W-1:0]   depth_limit_reg;

    logic s1_adv;   // result stage can take a new word
    logic step;     // decode the word held in the input stage

    assign s1_adv    = !out_valid_reg || out_ready;
    assign step      = s1_valid_reg && s1_adv;
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // decode of one byte against the current state
    always_comb
    begin
        logic [7:0] b;
        logic       hdr;
        logic       eoc;
        logic       err;
        logic       indef;
        logic       last;
        logic       finish;
        logic [2:0] role;

        b      = s1_data_reg.data_byte;
        hdr    = 1'b0;
        eoc    = 1'b0;
        err    = 1'b0;
        indef  = 1'b0;
        last   = 1'b0;
        finish = 1'b0;
        role   = ROLE_TAG_FIRST;

        // start of stream clears state ahead of the byte
        if (s1_data_reg.start_of_stream)
        begin
            phase_next        = PH_TAG_FIRST;
            tag_accum_next    = '0;
            tag_cnt_next      = '0;
            class_next        = '0;
            cons_next         = 1'b0;
            len_accum_next    = '0;
            len_left_next     = '0;
            content_left_next = '0;
            printable_next    = 1'b1;
            depth_next        = '0;
        end
        else
        begin
            phase_next        = phase_reg;
            tag_accum_next    = tag_accum_reg;
            tag_cnt_next      = tag_cnt_reg;
            class_next        = class_reg;
            cons_next         = cons_reg;
            len_accum_next    = len_accum_reg;
            len_left_next     = len_left_reg;
            content_left_next = content_left_reg;
            printable_next    = printable_reg;
            depth_next        = depth_reg;
        end

        unique case (phase_next)
            PH_TAG_CONT:
            begin
                role           = ROLE_TAG_CONT;
                tag_cnt_next   = tag_cnt_next + 1'b1;
                tag_accum_next = {tag_accum_next[TAG_W-8:0], b[6:0]};
                if (!b[7])
                begin
                    phase_next = PH_LEN_FIRST;
                end
                else if (32'(tag_cnt_next) >= MAX_TAG_BYTES)
                begin
                    err        = 1'b1;
                    phase_next = PH_TAG_FIRST;
                end
            end
            PH_LEN_FIRST:
            begin
                role           = ROLE_LEN_FIRST;
                len_accum_next = '0;
                if (b == LEN_INDEF)
                begin
                    indef      = 1'b1;
                    hdr        = 1'b1;
                    phase_next = PH_TAG_FIRST;
                    if (depth_next >= depth_limit_reg)
                        err = 1'b1;
                    else
                        depth_next = depth_next + 1'b1;
                end
                else if (!b[7])
                begin
                    len_accum_next = LEN_W'(b);
                    hdr            = 1'b1;
                    finish         = 1'b1;
                end
                else if (b[6:0] == LEN_RESERVED || 32'(b[6:0]) > MAX_LEN_BYTES)
                begin
                    err        = 1'b1;
                    phase_next = PH_TAG_FIRST;
                end
                else
                begin
                    len_left_next = LEN_CNT_W'(b[6:0]);
                    phase_next    = PH_LEN_CONT;
                end
            end
            PH_LEN_CONT:
            begin
                role           = ROLE_LEN_CONT;
                len_accum_next = {len_accum_next[LEN_W-9:0], b};
                if (len_left_next != '0)
                    len_left_next = len_left_next - 1'b1;
                if (len_left_next == '0)
                begin
                    hdr    = 1'b1;
                    finish = 1'b1;
                end
            end
            PH_CONTENT:
            begin
                role = ROLE_CONTENT;
                if (b < PRINT_LOW || b > PRINT_HIGH)
                    printable_next = 1'b0;
                if (content_left_next != '0)
                    content_left_next = content_left_next - 1'b1;
                if (content_left_next == '0)
                begin
                    last       = 1'b1;
                    phase_next = PH_TAG_FIRST;
                end
            end
            default:
            begin
                // tag first byte
                role           = ROLE_TAG_FIRST;
                class_next     = b[7:6];
                cons_next      = b[5];
                len_accum_next = '0;
                printable_next = 1'b1;
                tag_cnt_next   = '0;
                if ((b & TAG_NUM_MASK) != TAG_NUM_MASK)
                begin
                    tag_accum_next = TAG_W'(b[4:0]);
                    phase_next     = PH_LEN_FIRST;
                end
                else
                begin
                    tag_accum_next = '0;
                    phase_next     = PH_TAG_CONT;
                end
            end
        endcase

        // header finished with a definite length
        if (finish)
        begin
            if (class_next == 2'd0 && !cons_next && tag_accum_next == '0
                && len_accum_next == '0)
            begin
                // end-of-contents closes one indefinite level, or is an error at depth zero
                eoc        = 1'b1;
                phase_next = PH_TAG_FIRST;
                if (depth_next == '0)
                    err = 1'b1;
                else
                    depth_next = depth_next - 1'b1;
            end
            else if (len_accum_next != '0 && !cons_next)
            begin
                content_left_next = len_accum_next;
                printable_next    = 1'b1;
                phase_next        = PH_CONTENT;
            end
            else
            begin
                // constructed definite or empty primitive: next header follows
                phase_next = PH_TAG_FIRST;
            end
        end

        out_data_next.byte_role       = role;
        out_data_next.tag_class       = class_next;
        out_data_next.constructed     = cons_next;
        out_data_next.tag_number      = tag_accum_next;
        out_data_next.content_length  = len_accum_next;
        out_data_next.indefinite      = indef;
        out_data_next.header_done     = hdr;
        out_data_next.end_of_contents = eoc;
        out_data_next.nest_depth      = depth_next;
        out_data_next.content_last    = last;
        out_data_next.printable       = printable_next;
        out_data_next.error           = err;
    end

    // control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_TAG_FIRST;
            tag_accum_reg    <= '0;
            tag_cnt_reg      <= '0;
            class_reg        <= '0;
            cons_reg         <= 1'b0;
            len_accum_reg    <= '0;
            len_left_reg     <= '0;
            content_left_reg <= '0;
            printable_reg    <= 1'b1;
            depth_reg        <= '0;
            depth_limit_reg  <= 4'd15;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
            if (cfg_we)
                depth_limit_reg <= cfg_wdata;
            if (step)
            begin
                phase_reg        <= phase_next;
                tag_accum_reg    <= tag_accum_next;
                tag_cnt_reg      <= tag_cnt_next;
                class_reg        <= class_next;
                cons_reg         <= cons_next;
                len_accum_reg    <= len_accum_next;
                len_left_reg     <= len_left_next;
                content_left_reg <= content_left_next;
                printable_reg    <= printable_next;
                depth_reg        <= depth_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
        if (step)
            out_data_reg <= out_data_next;
    end

endmodule

// File: tb/sv/ber_tlv_stream_parser_tb.sv
`timescale 1ns / 100ps
// ber_tlv_stream_parser_tb: self-checking testbench for the ber tlv stream parser
// byte words go through a behavioral decoder; result words are compared with it
// or with a hand-written result; depends on btsp_pkg and ber_tlv_stream_parser
module ber_tlv_stream_parser_tb;
    import btsp_pkg::*;

    // one input word as queued for the sender, with an optional hand-written result
    typedef struct packed {
        in_item_t  word;
        logic      fixed;
        out_item_t res;
    } stim_word_t;

    localparam out_item_t NO_RESULT = '0;

    // directed words, walked in order with depth_limit at 1
    // rows with fixed set carry a result written out by hand, the rest use the decoder
    localparam stim_word_t DIRECTED [26] = '{
        // state right after reset, restart marker on the first byte
        '{'{8'h00, 1'b1}, 1'b1,
          '{ROLE_TAG_FIRST, 2'd0, 1'b0, 28'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b1, 1'b0}},
        // end-of-contents with nothing open: underflow
        '{'{8'h00, 1'b0}, 1'b1,
          '{ROLE_LEN_FIRST, 2'd0, 1'b0, 28'h0, 32'h0, 1'b0, 1'b1, 1'b1, 4'd0, 1'b0, 1'b1, 1'b1}},
        // private constructed, multi-byte tag that never ends
        '{'{8'hFF, 1'b0}, 1'b1,
          '{ROLE_TAG_FIRST, 2'd3, 1'b1, 28'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b1, 1'b0}},
        '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
        // fourth continuation byte still marked to go on: tag too long
        '{'{8'hFF, 1'b0}, 1'b1,
          '{ROLE_TAG_CONT, 2'd3, 1'b1, 28'hFFFFFFF, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b1,
            1'b1}},
        // sequence, indefinite: opens the one allowed level
        '{'{8'h30, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h80, 1'b0}, 1'b0, NO_RESULT},
        // second indefinite at the limit: overflow, depth stays
        '{'{8'h30, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h80, 1'b0}, 1'b1,
          '{ROLE_LEN_FIRST, 2'd0, 1'b1, 28'h10, 32'h0, 1'b1, 1'b1, 1'b0, 4'd1, 1'b0, 1'b1, 1'b1}},
        // octet string, four-byte long form length of 3
        '{'{8'h04, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h84, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h03, 1'b0}, 1'b0, NO_RESULT},
        // content: printable, then 0x7f breaks it, then the last byte
        '{'{8'h41, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h7F, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h20, 1'b0}, 1'b0, NO_RESULT},
        // end-of-contents closes the open level
        '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
        // reserved long form count
        '{'{8'h02, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 1'b0}, 1'b1,
          '{ROLE_LEN_FIRST, 2'd0, 1'b0, 28'h2, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b1, 1'b1}},
        // long form count one above the maximum
        '{'{8'h02, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h85, 1'b0}, 1'b0, NO_RESULT}
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_we    = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;

    // words waiting for the sender, and the one it is offering now
    stim_word_t byte_feed [$];
    stim_word_t next_word;
    stim_word_t offered = '0;

    // decoded result words not yet seen on the output, oldest first
    out_item_t decoded_words [$];
    out_item_t predicted;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          mismatches    = 0;

    // long receiver hold-off: requested by the main sequence, served by the receiver
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // stream generator bookkeeping
    int   words_queued    = 0;
    int   gen_depth       = 0;
    logic restart_pending = 1'b0;

    // behavioral copy of the parser state and its register
    phase_t      sim_phase        = PH_TAG_FIRST;
    logic [27:0] sim_tag          = '0;
    int          sim_tag_cnt      = 0;
    logic [1:0]  sim_class        = '0;
    logic        sim_cons         = 1'b0;
    logic [31:0] sim_len          = '0;
    int          sim_len_left     = 0;
    logic [31:0] sim_content_left = '0;
    logic        sim_printable    = 1'b1;
    logic [3:0]  sim_depth        = '0;
    logic [3:0]  sim_depth_limit  = 4'd15;

    ber_tlv_stream_parser dut (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .in_data,
        .out_valid,
        .out_ready,
        .out_data,
        .cfg_we,
        .cfg_wdata
    );

    always #5 clk = ~clk;

    // header finished with a definite length in sim_len
    task automatic close_definite(inout logic eoc, inout logic err);
        if (sim_class == 2'd0 && !sim_cons && sim_tag == '0 && sim_len == '0)
        begin
            // end-of-contents pair: close a level, or underflow at depth zero
            eoc = 1'b1;
            if (sim_depth == '0)
                err = 1'b1;
            else
                sim_depth = sim_depth - 4'd1;
            sim_phase = PH_TAG_FIRST;
        end
        else if (sim_len != '0 && !sim_cons)
        begin
            sim_content_left = sim_len;
            sim_printable    = 1'b1;
            sim_phase        = PH_CONTENT;
        end
        else
            sim_phase = PH_TAG_FIRST;
    endtask

    // advance the behavioral parser by one byte word and give its result word
    task automatic decode_byte(input in_item_t w, output out_item_t r);
        logic [7:0] b;
        logic [6:0] n;
        logic [2:0] role;
        logic       indef, hdr, eoc, last, err;
        b     = w.data_byte;
        indef = 1'b0;
        hdr   = 1'b0;
        eoc   = 1'b0;
        last  = 1'b0;
        err   = 1'b0;
        // restart marker wipes the parse state but keeps depth_limit
        if (w.start_of_stream)
        begin
            sim_phase        = PH_TAG_FIRST;
            sim_tag          = '0;
            sim_tag_cnt      = 0;
            sim_class        = '0;
            sim_cons         = 1'b0;
            sim_len          = '0;
            sim_len_left     = 0;
            sim_content_left = '0;
            sim_printable    = 1'b1;
            sim_depth        = '0;
        end
        case (sim_phase)
            PH_TAG_CONT:
            begin
                role        = ROLE_TAG_CONT;
                sim_tag_cnt = sim_tag_cnt + 1;
                sim_tag     = {sim_tag[20:0], b[6:0]};
                if (!b[7])
                    sim_phase = PH_LEN_FIRST;
                else if (sim_tag_cnt >= MAX_TAG_BYTES)
                begin
                    err       = 1'b1;
                    sim_phase = PH_TAG_FIRST;
                end
            end
            PH_LEN_FIRST:
            begin
                role    = ROLE_LEN_FIRST;
                sim_len = '0;
                if (b == LEN_INDEF)
                begin
                    // indefinite form opens a level unless the limit is reached
                    indef = 1'b1;
                    hdr   = 1'b1;
                    if (sim_depth >= sim_depth_limit)
                        err = 1'b1;
                    else
                        sim_depth = sim_depth + 4'd1;
                    sim_phase = PH_TAG_FIRST;
                end
                else if (!b[7])
                begin
                    sim_len = {24'd0, b};
                    hdr     = 1'b1;
                    close_definite(eoc, err);
                end
                else
                begin
                    n = b[6:0];
                    if (n == LEN_RESERVED || n > MAX_LEN_BYTES)
                    begin
                        err       = 1'b1;
                        sim_phase = PH_TAG_FIRST;
                    end
                    else
                    begin
                        sim_len_left = n;
                        sim_phase    = PH_LEN_CONT;
                    end
                end
            end
            PH_LEN_CONT:
            begin
                role    = ROLE_LEN_CONT;
                sim_len = {sim_len[23:0], b};
                if (sim_len_left > 0)
                    sim_len_left = sim_len_left - 1;
                if (sim_len_left == 0)
                begin
                    hdr = 1'b1;
                    close_definite(eoc, err);
                end
            end
            PH_CONTENT:
            begin
                role = ROLE_CONTENT;
                if (b < PRINT_LOW || b > PRINT_HIGH)
                    sim_printable = 1'b0;
                if (sim_content_left != '0)
                    sim_content_left = sim_content_left - 32'd1;
                if (sim_content_left == '0)
                begin
                    last      = 1'b1;
                    sim_phase = PH_TAG_FIRST;
                end
            end
            default:
            begin
                // identifier first byte: class, constructed bit, short or long tag
                role          = ROLE_TAG_FIRST;
                sim_class     = b[7:6];
                sim_cons      = b[5];
                sim_len       = '0;
                sim_printable = 1'b1;
                sim_tag_cnt   = 0;
                if (b[4:0] != TAG_NUM_MASK[4:0])
                begin
                    sim_tag   = {23'd0, b[4:0]};
                    sim_phase = PH_LEN_FIRST;
                end
                else
                begin
                    sim_tag   = '0;
                    sim_phase = PH_TAG_CONT;
                end
            end
        endcase
        r = '{role, sim_class, sim_cons, sim_tag, sim_len, indef, hdr, eoc, sim_depth, last,
              sim_printable, err};
    endtask

    function automatic bit same_word(out_item_t a, out_item_t b);
        return a.byte_role === b.byte_role && a.tag_class === b.tag_class
            && a.constructed === b.constructed && a.tag_number === b.tag_number
            && a.content_length === b.content_length && a.indefinite === b.indefinite
            && a.header_done === b.header_done && a.end_of_contents === b.end_of_contents
            && a.nest_depth === b.nest_depth && a.content_last === b.content_last
            && a.printable === b.printable && a.error === b.error;
    endfunction

    function automatic string show(out_item_t w);
        return $sformatf({"role %0d class %0d cons %0b tag %h len %h indef %0b hdr %0b ",
                          "eoc %0b depth %0d last %0b print %0b err %0b"},
                         w.byte_role, w.tag_class, w.constructed, w.tag_number,
                         w.content_length, w.indefinite, w.header_done, w.end_of_contents,
                         w.nest_depth, w.content_last, w.printable, w.error);
    endfunction

    task automatic report(string what, out_item_t want, out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s\n  want %s\n  got  %s", what, show(want), show(got));
    endtask

    // sender: new word only when nothing is offered or the offered one just went in
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_word = byte_feed.pop_front();
                in_valid <= 1'b1;
                in_data  <= next_word.word;
                offered  <= next_word;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left   <= 400;
            out_ready   <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result words are checked first, then the word accepted at this edge is decoded
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_words.size() == 0)
                    report("result word with nothing awaited", NO_RESULT, out_data);
                else if (!same_word(decoded_words[0], out_data))
                    report("result word differs", decoded_words.pop_front(), out_data);
                else
                    void'(decoded_words.pop_front());
            end
            if (in_valid && in_ready)
            begin
                decode_byte(offered.word, predicted);
                if (offered.fixed)
                    decoded_words.push_back(offered.res);
                else
                    decoded_words.push_back(predicted);
            end
        end
    end

    task automatic push_byte(logic [7:0] b);
        stim_word_t s;
        s.word          = '{b, restart_pending};
        s.fixed         = 1'b0;
        s.res           = NO_RESULT;
        restart_pending = 1'b0;
        byte_feed.push_back(s);
        words_queued++;
    endtask

    task automatic restart_stream();
        restart_pending = 1'b1;
        gen_depth       = 0;
    endtask

    // mostly well-formed tlv items with random content, some stray and broken bytes
    task automatic queue_random_stream(int n_words);
        int          target, pick, n_cont, n_len, min_len, i;
        logic [1:0]  cls;
        logic        cons, text_only, too_long;
        logic [31:0] len;
        target = words_queued + n_words;
        while (words_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                // stray byte, now and then with a restart marker
                if ($urandom_range(0, 3) == 0)
                    restart_stream();
                push_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 6)
                restart_stream();
            else if (pick < 8 || (pick < 20 && gen_depth != 0))
            begin
                // end-of-contents pair, also at depth zero now and then
                push_byte(8'h00);
                push_byte(8'h00);
                if (gen_depth != 0)
                    gen_depth--;
            end
            else
            begin
                cls  = 2'($urandom_range(0, 3));
                cons = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 3) != 0)
                    push_byte({cls, cons, 5'($urandom_range(0, 30))});
                else
                begin
                    push_byte({cls, cons, TAG_NUM_MASK[4:0]});
                    n_cont   = $urandom_range(1, MAX_TAG_BYTES);
                    too_long = (n_cont == MAX_TAG_BYTES) && ($urandom_range(0, 5) == 0);
                    for (i = 1; i <= n_cont; i++)
                        push_byte({(i < n_cont) || too_long, 7'($urandom())});
                    if (too_long)
                        continue;
                end
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    push_byte(8'h80 | 8'($urandom_range(MAX_LEN_BYTES + 1, 127)));
                else if (pick < 8 || (cons && pick < 40))
                begin
                    push_byte(LEN_INDEF);
                    gen_depth++;
                end
                else
                begin
                    // constructed items take any length, primitive ones stay short
                    if (cons && $urandom_range(0, 1) == 0)
                        len = $urandom();
                    else if ($urandom_range(0, 9) == 0)
                        len = $urandom_range(7, 40);
                    else
                        len = $urandom_range(0, 6);
                    if (len < 128 && $urandom_range(0, 4) < 3)
                        push_byte(len[7:0]);
                    else
                    begin
                        min_len = (len > 32'hFFFFFF) ? 4 : (len > 32'hFFFF) ? 3 :
                                  (len > 32'hFF) ? 2 : 1;
                        n_len = $urandom_range(min_len, MAX_LEN_BYTES);
                        push_byte(8'h80 | 8'(n_len));
                        for (i = n_len - 1; i >= 0; i--)
                            push_byte(len[8*i +: 8]);
                    end
                    if (!cons)
                    begin
                        text_only = 1'($urandom_range(0, 1));
                        for (i = 0; i < len; i++)
                            push_byte(text_only ? 8'($urandom_range(PRINT_LOW, PRINT_HIGH))
                                                : 8'($urandom()));
                    end
                end
            end
        end
    endtask

    // block is idle here; the decoder's copy of the register follows the write
    task automatic write_depth_limit(logic [3:0] v);
        @(posedge clk);
        cfg_we          <= 1'b1;
        cfg_wdata       <= v;
        sim_depth_limit  = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // wait until every word is in and every result word is out
    task automatic drain();
        while (byte_feed.size() != 0 || in_valid || decoded_words.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(logic [3:0] limit, int unsigned send_pct, int unsigned recv_pct,
                             bit hold_off);
        write_depth_limit(limit);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        restart_stream();
        if (hold_off)
            hold_requests++;
        queue_random_stream(256);
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words at depth limit 1, no idling
        write_depth_limit(4'd1);
        foreach (DIRECTED[i])
            byte_feed.push_back(DIRECTED[i]);
        drain();

        // random streams: limits 15 and 1 and one in between
        run_phase(4'd15, 18, 45, 1'b0);
        run_phase(4'd1, 45, 18, 1'b0);
        run_phase(4'($urandom_range(2, 14)), 0, 0, 1'b0);
        // receiver holds off while the sender keeps offering
        run_phase(4'd3, 0, 0, 1'b1);

        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit, well past the slowest legal run
    initial
    begin
        #500000;
        $display("simulation failed");
        $finish;
    end

endmodule
